// ===== hw/rtl/line_fold_wrapper_top_defines.svh =====
// ----------------------------------------------------------------------------
// line_fold_wrapper_top_defines
// Assertion macros for the line folder.
// ----------------------------------------------------------------------------
`ifndef LINE_FOLD_WRAPPER_TOP_DEFINES_SVH
`define LINE_FOLD_WRAPPER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define LFW_ASSERT(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define LFW_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define LFW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LFW_ASSERT(lbl, clk, rst_n, expr, msg)
`define LFW_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define LFW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== hw/rtl/lfw_pkg.sv =====
// ----------------------------------------------------------------------------
// lfw_pkg
// Types and constants of the line folder.
// ----------------------------------------------------------------------------
package lfw_pkg;

    localparam int unsigned COL_W  = 6;
    localparam int unsigned BYTE_W = 8;

    typedef logic [COL_W-1:0]  t_col;
    typedef logic [BYTE_W-1:0] t_byte;

    localparam t_byte CH_TAB   = 8'd9;
    localparam t_byte CH_NL    = 8'd10;
    localparam t_byte CH_BLANK = 8'd32;

    localparam t_col FOLD_RESET = 6'd20;
    localparam t_col FOLD_MIN   = 6'd2;

endpackage

// ===== hw/rtl/lfw_ram.sv =====
// ----------------------------------------------------------------------------
// lfw_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module lfw_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/line_fold_wrapper_top.sv =====
// ----------------------------------------------------------------------------
// line_fold_wrapper_top
// Fixed-width line folder with word wrap over a byte stream.
//
//   channel   dir  handshake                        payload
//   s_axis    in   s_axis_tvalid / s_axis_tready    tdata[7:0] in_byte
//   m_axis    out  m_axis_tvalid / m_axis_tready    tdata[7:0] out_byte, tlast
//   cfg       in   i_cfg_we                         i_cfg_wdata[5:0] fold_width
//
// An ordinary byte that does not fold goes to the line store as it is taken.
// A tab writes blanks up to the next tab stop or the fold. An emitted line
// reads each byte from the line store, then loads it into the output, then sends
// the newline; a fold then moves the rest through the line store port. Input
// is held off in a tab, line output, move or width write; the output register
// lets one byte wait. Reset is synchronous; the line store needs no clearing.
// ----------------------------------------------------------------------------
`include "line_fold_wrapper_top_defines.svh"

module line_fold_wrapper_top #(
    parameter int unsigned MAX_WIDTH = 32,
    parameter int unsigned TAB_STEP  = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  lfw_pkg::t_col       i_cfg_wdata,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  lfw_pkg::t_byte      s_axis_tdata,   // [7:0] in_byte
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output lfw_pkg::t_byte      m_axis_tdata,   // [7:0] out_byte
    output logic                m_axis_tlast    // last_of_run
);

    import lfw_pkg::*;

    localparam int unsigned AW = $clog2(MAX_WIDTH);
    localparam int unsigned PW = $clog2(TAB_STEP);
    localparam t_col        MAXW = t_col'(MAX_WIDTH);
    localparam logic [PW-1:0] PH_LAST = PW'(TAB_STEP - 1);

    typedef enum logic [2:0] {
        S_IDLE, S_TAB, S_RD, S_OUT, S_NL, S_MV_RD, S_MV_WR
    } t_state;

    t_state        r_state;
    t_col          r_fold;
    t_col          r_col;
    logic [PW-1:0] r_phase;
    t_col          r_blank_pos;
    logic          r_blank_vld;
    t_col          r_len;
    t_col          r_idx;
    t_col          r_src;
    logic          r_move;
    t_byte         r_out_byte;
    logic          r_out_last;
    logic          r_out_vld;

    t_col          w_eff;
    t_col          col_eff;
    t_col          col_inc;
    logic [PW-1:0] phase_inc;
    logic          in_acc;
    logic          out_rdy;
    logic          out_load;
    logic          cur_blank_vld;
    t_col          cur_blank_pos;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    t_byte         ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    t_byte         ram_rdata;

    assign w_eff = (r_fold < FOLD_MIN) ? FOLD_MIN : ((r_fold > MAXW) ? MAXW : r_fold);
    assign col_eff   = (r_col >= w_eff) ? '0 : r_col;
    assign col_inc   = col_eff + 6'd1;
    assign phase_inc = (r_phase == PH_LAST) ? '0 : r_phase + 1'b1;
    assign in_acc    = s_axis_tvalid && s_axis_tready;
    assign out_rdy   = !r_out_vld || m_axis_tready;
    assign out_load  = !i_cfg_we && (r_state == S_OUT || r_state == S_NL) && out_rdy;

    // blank tracking including the byte written this cycle
    always_comb begin
        cur_blank_vld = r_blank_vld;
        cur_blank_pos = r_blank_pos;
        if (col_eff != '0 && (r_state == S_TAB || s_axis_tdata == CH_BLANK)) begin
            cur_blank_vld = 1'b1;
            cur_blank_pos = col_eff;
        end
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = col_eff[AW-1:0];
        ram_wdata = s_axis_tdata;
        ram_re    = 1'b0;
        ram_raddr = r_idx[AW-1:0];
        unique case (r_state)
            S_IDLE: begin
                ram_we = in_acc && !i_cfg_we && s_axis_tdata != CH_TAB
                         && s_axis_tdata != CH_NL;
            end
            S_TAB: begin
                ram_we    = 1'b1;
                ram_wdata = CH_BLANK;
            end
            S_RD: begin
                ram_re = 1'b1;
            end
            S_MV_RD: begin
                ram_re    = 1'b1;
                ram_raddr = r_src[AW-1:0];
            end
            S_MV_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_idx[AW-1:0];
                ram_wdata = ram_rdata;
            end
            default: begin
            end
        endcase
    end

    lfw_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fold      <= FOLD_RESET;
            r_col       <= '0;
            r_phase     <= '0;
            r_blank_vld <= 1'b0;
            r_move      <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
            if (i_cfg_we) begin
                // width change drops the buffered line
                r_fold      <= i_cfg_wdata;
                r_col       <= '0;
                r_phase     <= '0;
                r_blank_vld <= 1'b0;
                r_move      <= 1'b0;
                r_state     <= S_IDLE;
            end else begin
                unique case (r_state)
                    S_IDLE: begin
                        if (in_acc) begin
                            r_idx <= '0;
                            priority if (s_axis_tdata == CH_TAB) begin
                                r_state <= S_TAB;
                            end else if (s_axis_tdata == CH_NL) begin
                                r_col       <= '0;
                                r_phase     <= '0;
                                r_blank_vld <= 1'b0;
                                if (col_eff != '0) begin
                                    r_len   <= col_eff;
                                    r_move  <= 1'b0;
                                    r_state <= S_RD;
                                end
                            end else if (col_inc >= w_eff) begin
                                r_col       <= '0;
                                r_phase     <= '0;
                                r_blank_vld <= 1'b0;
                                r_state     <= S_RD;
                                if (cur_blank_vld && cur_blank_pos != w_eff - 6'd1) begin
                                    r_len  <= cur_blank_pos + 6'd1;
                                    r_src  <= cur_blank_pos + 6'd1;
                                    r_move <= 1'b1;
                                end else begin
                                    r_len  <= w_eff;
                                    r_move <= 1'b0;
                                end
                            end else begin
                                r_col       <= col_inc;
                                r_phase     <= phase_inc;
                                r_blank_vld <= cur_blank_vld;
                                r_blank_pos <= cur_blank_pos;
                            end
                        end
                    end
                    S_TAB: begin
                        if (col_inc >= w_eff) begin
                            r_col       <= '0;
                            r_phase     <= '0;
                            r_blank_vld <= 1'b0;
                            r_len       <= w_eff;
                            r_move      <= 1'b0;
                            r_state     <= S_RD;
                        end else begin
                            r_col       <= col_inc;
                            r_phase     <= phase_inc;
                            r_blank_vld <= cur_blank_vld;
                            r_blank_pos <= cur_blank_pos;
                            if (phase_inc == '0) begin
                                r_state <= S_IDLE;
                            end
                        end
                    end
                    S_RD: begin
                        r_state <= S_OUT;
                    end
                    S_OUT: begin
                        if (out_rdy) begin
                            r_out_byte <= ram_rdata;
                            r_out_last <= 1'b0;
                            r_idx      <= r_idx + 6'd1;
                            r_state    <= (r_idx + 6'd1 == r_len) ? S_NL : S_RD;
                        end
                    end
                    S_NL: begin
                        if (out_rdy) begin
                            r_out_byte <= CH_NL;
                            r_out_last <= 1'b1;
                            r_idx      <= '0;
                            r_state    <= r_move ? S_MV_RD : S_IDLE;
                        end
                    end
                    S_MV_RD: begin
                        r_state <= S_MV_WR;
                    end
                    S_MV_WR: begin
                        r_idx   <= r_idx + 6'd1;
                        r_src   <= r_src + 6'd1;
                        r_phase <= phase_inc;
                        if (r_src + 6'd1 == w_eff) begin
                            r_col   <= r_idx + 6'd1;
                            r_move  <= 1'b0;
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_MV_RD;
                        end
                    end
                    default: begin
                        r_state <= S_IDLE;
                    end
                endcase
            end
        end
    end

    assign s_axis_tready = (r_state == S_IDLE) && !i_cfg_we;
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_byte;
    assign m_axis_tlast  = r_out_last;

    `LFW_ASSERT(a_col_below_width, i_clk, i_rst_n, r_col < w_eff, "column reached fold width")
    `LFW_ASSERT_IMPL(a_blank_in_line, i_clk, i_rst_n, r_blank_vld,
        r_blank_pos != '0 && r_blank_pos < r_col, "tracked blank outside line")
    `LFW_ASSERT_IMPL(a_fold_len, i_clk, i_rst_n, r_move && r_state == S_RD,
        r_len < w_eff && r_src == r_len, "fold cut out of range")
    `LFW_ASSERT_NEXT(a_nl_last, i_clk, i_rst_n, r_state == S_NL && out_load,
        m_axis_tvalid && m_axis_tlast && m_axis_tdata == CH_NL, "run not closed by newline")

endmodule
